/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Stable priority queue package
// Sizes, status codes and the command bundle that the controller sends to
// the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int VALUE_W       = 32;
    localparam int PORT_PRI_W    = 8;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        STATUS_PUSHED = 2'd0,
        STATUS_POPPED = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming request word
        logic exec;   // apply the captured request and register its result
    } spq_cmd_t;

endpackage

/* rtl/core/spq_datapath.sv */
// ----------------------------------------------------------------------------
// Stable priority queue datapath
// Sorted register array with a parallel compare that finds the insertion
// slot, a parallel shift for push and pop, and the result register.
// ----------------------------------------------------------------------------
module spq_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  spq_pkg::spq_cmd_t                   cmd,
    input  logic                                req_type,
    input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic [spq_pkg::PORT_PRI_W-1:0]      item_priority,
    output logic signed [spq_pkg::VALUE_W-1:0]  popped_value,
    output logic [spq_pkg::PORT_PRI_W-1:0]      popped_priority,
    output logic [1:0]                          status,
    output logic [spq_pkg::COUNT_W-1:0]         occupancy
);
    import spq_pkg::*;

    logic                      req_type_reg;
    logic [VALUE_W-1:0]        req_value_reg;
    logic [PRIORITY_BITS-1:0]  req_pri_reg;

    logic [VALUE_W-1:0]        val_reg  [CAPACITY];
    logic [PRIORITY_BITS-1:0]  pri_reg  [CAPACITY];
    logic [VALUE_W-1:0]        val_next [CAPACITY];
    logic [PRIORITY_BITS-1:0]  pri_next [CAPACITY];
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;

    logic [VALUE_W-1:0]        res_value_reg,  res_value_next;
    logic [PRIORITY_BITS-1:0]  res_pri_reg,    res_pri_next;
    status_t                   res_status_reg, res_status_next;

    // A slot is at or after the insertion point when it is empty or holds a
    // strictly greater priority. The array is sorted, so the mask is monotonic.
    logic [CAPACITY-1:0]       ins_mask;
    logic                      is_full;
    logic                      is_empty;

    assign is_full  = (count_reg == COUNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ins_mask[i] = (COUNT_W'(i) >= count_reg) || (pri_reg[i] > req_pri_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
        end
        count_next      = count_reg;
        res_value_next  = '0;
        res_pri_next    = '0;
        res_status_next = STATUS_PUSHED;

        if (req_type_reg == REQ_PUSH)
        begin
            if (is_full)
            begin
                res_status_next = STATUS_FULL;
            end
            else
            begin
                if (ins_mask[0])
                begin
                    val_next[0] = req_value_reg;
                    pri_next[0] = req_pri_reg;
                end
                for (int i = 1; i < CAPACITY; i++)
                begin
                    if (ins_mask[i])
                    begin
                        if (!ins_mask[i-1])
                        begin
                            val_next[i] = req_value_reg;
                            pri_next[i] = req_pri_reg;
                        end
                        else
                        begin
                            val_next[i] = val_reg[i-1];
                            pri_next[i] = pri_reg[i-1];
                        end
                    end
                end
                count_next      = count_reg + COUNT_W'(1);
                res_status_next = STATUS_PUSHED;
            end
        end
        else
        begin
            if (is_empty)
            begin
                res_status_next = STATUS_EMPTY;
            end
            else
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    val_next[i] = val_reg[i+1];
                    pri_next[i] = pri_reg[i+1];
                end
                res_value_next  = val_reg[0];
                res_pri_next    = pri_reg[0];
                count_next      = count_reg - COUNT_W'(1);
                res_status_next = STATUS_POPPED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg  <= req_type;
            req_value_reg <= item_value;
            req_pri_reg   <= item_priority[PRIORITY_BITS-1:0];
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                val_reg[i] <= val_next[i];
                pri_reg[i] <= pri_next[i];
            end
            res_value_reg  <= res_value_next;
            res_pri_reg    <= res_pri_next;
            res_status_reg <= res_status_next;
        end
    end

    // The occupancy follows the count, which only changes on the next exec.
    assign popped_value    = res_value_reg;
    assign popped_priority = PORT_PRI_W'(res_pri_reg);
    assign status          = res_status_reg;
    assign occupancy       = count_reg;

endmodule

/* rtl/core/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// Stable priority queue controller
// Takes a request word, schedules its execution once the result register is
// free, and drives both handshakes.
// ----------------------------------------------------------------------------
module spq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output spq_pkg::spq_cmd_t  cmd
);
    import spq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   res_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Hold the request until the previous result word has left.
                if (res_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded min-first queue of (priority, value) entries; equal priorities
// leave in arrival order.
//
// Usage: each input word is a push (req_type 0) or a pop (req_type 1). It is
// taken when in_valid is high and in_stall is low. Every request gives one
// result word on the output channel with the popped entry (zero otherwise),
// a status code and the occupancy after the request.
// Result: a taken request is captured in the request register and applied
// to the sorted array and result register once the result register is free.
// Order: the word is registered first, and the sorted register array is then
// compared and shifted; a new request waits until the last one is applied.
// The next request is taken while the previous result still waits.
// Stall: if out_stall holds a result, one further request is taken and then
// waits, with in_stall high, until the result register is free.
// Reset: the queue becomes empty and no result is valid; entry storage is
// not cleared, since only slots below the count are read.
// ----------------------------------------------------------------------------
module stable_priority_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic [spq_pkg::PORT_PRI_W-1:0]      item_priority,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [spq_pkg::VALUE_W-1:0]  popped_value,
    output logic [spq_pkg::PORT_PRI_W-1:0]      popped_priority,
    output logic [1:0]                          status,
    output logic [spq_pkg::COUNT_W-1:0]         occupancy
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spq_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .req_type        (req_type),
        .item_value      (item_value),
        .item_priority   (item_priority),
        .popped_value    (popped_value),
        .popped_priority (popped_priority),
        .status          (status),
        .occupancy       (occupancy)
    );

endmodule
